### rtl/pib_pkg.sv
// Shared types and constants for the palette index builder.
package pib_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned RGB_W      = 3 * CHAN_W;
  localparam int unsigned INDEX_W    = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_THRESHOLD = 2'd1;

  localparam logic              ALPHA_PRESENT_RST = 1'b1;
  localparam logic [CHAN_W-1:0] THRESHOLD_RST     = 8'd127;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'd255;

  typedef struct packed {
    logic load;     // latch accepted pixel, restart scan
    logic step;     // issue next table read
    logic resolve;  // form result, store new color
  } pib_cmd_t;

  typedef struct packed {
    logic transparent;
    logic hit;
    logic miss_done;
  } pib_status_t;

endpackage

### rtl/palette_index_builder.sv
// Top level of the palette index builder.
// One RGBA pixel word in, one palette index word out. After a pixel is accepted, the
// color table scan ends at once for a transparent pixel or a miss against an empty
// table, at the matching color on a hit, and after every stored color on a miss
// against a non-empty table; the next pixel is accepted once the result is formed.
// The scan reads one stored color per cycle through the single read port of the table
// RAM. A result waiting in the output register does not block acceptance of the
// next pixel; it only holds the scan's final cycle.
// The table needs no clearing pass: a fill count bounds every scan.
module palette_index_builder #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pib_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_start_of_image,
  input  logic [pib_pkg::CHAN_W-1:0]     in_red,
  input  logic [pib_pkg::CHAN_W-1:0]     in_green,
  input  logic [pib_pkg::CHAN_W-1:0]     in_blue,
  input  logic [pib_pkg::CHAN_W-1:0]     in_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pib_pkg::INDEX_W-1:0]    out_color_index,
  output logic                           out_new_color,
  output logic                           out_table_overflow
);
  import pib_pkg::*;

  pib_cmd_t    cmd;
  pib_status_t status;

  assign cfg_ready = 1'b1;

  pib_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pib_dp #(
    .MAX_COLORS (MAX_COLORS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_start_of_image  (in_start_of_image),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_alpha           (in_alpha),
    .cmd                (cmd),
    .status             (status),
    .out_color_index    (out_color_index),
    .out_new_color      (out_new_color),
    .out_table_overflow (out_table_overflow)
  );

endmodule

### rtl/pib_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pib_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pib_ctrl.sv
// Controller: accepts a pixel, runs the table scan, hands the result to the output.
module pib_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pib_pkg::pib_status_t status,
  output pib_pkg::pib_cmd_t    cmd
);
  import pib_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   done;
  logic   slot_free;

  assign done      = status.transparent | status.hit | status.miss_done;
  assign slot_free = ~out_valid_r | out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = in_valid & in_ready;
    cmd.step    = (state_r == S_SCAN) & ~done;
    cmd.resolve = (state_r == S_SCAN) & done & slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd.resolve) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/pib_dp.sv
// Datapath: config registers, pixel latch, color table scan and result register.
module pib_dp #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr,
  input  logic [pib_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pib_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_start_of_image,
  input  logic [pib_pkg::CHAN_W-1:0]       in_red,
  input  logic [pib_pkg::CHAN_W-1:0]       in_green,
  input  logic [pib_pkg::CHAN_W-1:0]       in_blue,
  input  logic [pib_pkg::CHAN_W-1:0]       in_alpha,
  input  pib_pkg::pib_cmd_t                cmd,
  output pib_pkg::pib_status_t             status,
  output logic [pib_pkg::INDEX_W-1:0]      out_color_index,
  output logic                             out_new_color,
  output logic                             out_table_overflow
);
  import pib_pkg::*;

  localparam int unsigned AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLORS + 1);
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

  logic              alpha_present_r;
  logic [CHAN_W-1:0] threshold_r;

  logic [RGB_W-1:0]  pix_r;
  logic              trans_r;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     scan_r;
  logic              cmp_vld_r;
  logic [AW-1:0]     cmp_idx_r;

  logic [CHAN_W-1:0] alpha_eff;
  logic              issue;
  logic              full;
  logic              store;
  logic [RGB_W-1:0]  rd_data;
  logic [CW-1:0]     idx_cw;
  logic [IW-1:0]     idx_wide;

  // Config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_present_r <= ALPHA_PRESENT_RST;
      threshold_r     <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ALPHA_PRESENT:     alpha_present_r <= cfg_data[0];
        CFG_OPACITY_THRESHOLD: threshold_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign alpha_eff = alpha_present_r ? in_alpha : ALPHA_OPAQUE;

  assign issue = cmd.step & (scan_r != used_r);
  assign full  = (used_r == CW'(MAX_COLORS));
  assign store = cmd.resolve & ~status.transparent & ~status.hit & ~full;

  assign status.transparent = trans_r;
  assign status.hit         = ~trans_r & cmp_vld_r & (rd_data == pix_r);
  assign status.miss_done   = ~trans_r & ~cmp_vld_r & (scan_r == used_r);

  always_comb begin
    used_nxt = used_r;
    if (cmd.load && in_start_of_image) begin
      used_nxt = '0;
    end else if (store) begin
      used_nxt = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
      trans_r   <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cmd.load) begin
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
        trans_r   <= (alpha_eff < threshold_r);
      end else if (cmd.step) begin
        // hold pipeline while stalled so rd_data stays with cmp_idx_r
        cmp_vld_r <= issue;
        if (issue) begin
          scan_r <= scan_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= {in_red, in_green, in_blue};
    end
    if (issue) begin
      cmp_idx_r <= scan_r[AW-1:0];
    end
  end

  pib_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_COLORS)
  ) u_table (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (used_r[AW-1:0]),
    .wr_data (pix_r),
    .rd_en   (issue),
    .rd_addr (scan_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    priority if (status.transparent) begin
      idx_cw = '0;
    end else if (status.hit) begin
      idx_cw = CW'(cmp_idx_r) + 1'b1;
    end else if (full) begin
      idx_cw = '0;
    end else begin
      idx_cw = used_r + 1'b1;
    end
  end

  assign idx_wide = IW'(idx_cw);

  // Result register, loaded when the output slot is free
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_color_index    <= idx_wide[INDEX_W-1:0];
      out_new_color      <= store;
      out_table_overflow <= ~status.transparent & ~status.hit & full;
    end
  end

endmodule
